// ===== src/brt_pkg.sv =====
// Package with the shared types and constants of the block reception tracker.
package brt_pkg;

  // Field widths of the parsed packet and of one reply item.
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned FILE_W  = 32;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned BLEN_W  = 16;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned VALUE_W = 12;

  // Bitmap rows: each memory word holds the missing marks of this many blocks.
  localparam int unsigned ROW_W  = 16;
  localparam int unsigned ROW_BW = 4;

  // Request types.
  typedef enum logic [REQ_W-1:0] {
    REQ_START  = 2'd0,
    REQ_DATA   = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  // Status codes carried in a reply.
  typedef enum logic [CODE_W-1:0] {
    ST_NOTHING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_MISSING  = 2'd2,
    ST_UNUSED   = 2'd3
  } status_code_e;

  // Kinds of reply item.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef logic [ROW_W-1:0] row_t;

endpackage

// ===== src/block_reception_tracker.sv =====
// Top level of the block reception tracker: divider, bitmap memory and reply sequencer.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-------------------------------------------
//  in      | input     | in_valid_i / in_ready_o | req_type, frame_ok, file_number, file_size,
//          |           |                         | block_length, block_seq
//  out     | output    | out_valid_o/out_ready_i | item_kind, status_code, reply_file,
//          |           |                         | value, last
//
// One request is handled at a time; in_ready_o is high only while the sequencer is idle.
// A start request runs the bit-serial divider, then fills one bitmap row per cycle
// (ceil(blocks / 16) rows) to mark every block missing. A data request read-modify-writes
// its row. A status request sends the header, then lists the entries of each scanned row,
// one per cycle while the output is free; the scan stops at the last entry. Reset clears
// the file number, block count and missing count; the bitmap is written by the next start.
// A stalled output register holds the sequencer until it is taken.
module block_reception_tracker #(
  parameter int unsigned MAX_BLOCKS = 4096,
  parameter int unsigned MAX_REPORT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [brt_pkg::REQ_W-1:0]    req_type_i,
  input  logic                         frame_ok_i,
  input  logic [brt_pkg::FILE_W-1:0]   file_number_i,
  input  logic [brt_pkg::SIZE_W-1:0]   file_size_i,
  input  logic [brt_pkg::BLEN_W-1:0]   block_length_i,
  input  logic [brt_pkg::SEQ_W-1:0]    block_seq_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         item_kind_o,
  output logic [brt_pkg::CODE_W-1:0]   status_code_o,
  output logic [brt_pkg::FILE_W-1:0]   reply_file_o,
  output logic [brt_pkg::VALUE_W-1:0]  value_o,
  output logic                         last_o
);
  import brt_pkg::*;

  localparam int unsigned ROWS  = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int unsigned RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned LW    = $clog2(MAX_REPORT + 1);
  localparam int unsigned DCW   = $clog2(SIZE_W);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_DCHK = 4'd2;
  localparam logic [3:0] S_FILL = 4'd3;
  localparam logic [3:0] S_DRD  = 4'd4;
  localparam logic [3:0] S_DWR  = 4'd5;
  localparam logic [3:0] S_HDR  = 4'd6;
  localparam logic [3:0] S_SRD  = 4'd7;
  localparam logic [3:0] S_SLD  = 4'd8;
  localparam logic [3:0] S_SCAN = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [FILE_W-1:0]   cur_file_q, cur_file_d;
  logic [BT_W-1:0]     blk_total_q, blk_total_d;
  logic [BT_W-1:0]     miss_cnt_q, miss_cnt_d;
  logic [FILE_W-1:0]   new_file_q, new_file_d;
  logic [SIZE_W-1:0]   quo_q, quo_d;
  logic [BLEN_W-1:0]   rem_q, rem_d;
  logic [BLEN_W-1:0]   dvs_q, dvs_d;
  logic [DCW-1:0]      div_cnt_q, div_cnt_d;
  logic [RAW-1:0]      row_q, row_d;
  logic [ROW_BW-1:0]   bit_q, bit_d;
  logic [RAW-1:0]      last_row_q, last_row_d;
  logic [CODE_W-1:0]   code_q, code_d;
  logic [LW-1:0]       listed_q, listed_d;
  logic [LW-1:0]       emit_q, emit_d;
  row_t                work_q, work_d;

  logic                out_valid_q, out_valid_d;
  logic                kind_q, kind_d;
  logic [CODE_W-1:0]   ocode_q, ocode_d;
  logic [FILE_W-1:0]   ofile_q, ofile_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic                last_q, last_d;

  // Bitmap memory: one row of missing marks per word, read data registered.
  row_t                mem [ROWS];
  row_t                rd_q;
  logic                mem_we;
  row_t                mem_wdata;

  logic                in_fire;
  logic                slot_free;
  logic [BLEN_W:0]     div_trial;
  logic                div_take;
  logic [SIZE_W:0]     blk_count;
  row_t                row_mask;
  logic [ROW_BW-1:0]   first_bit;
  logic [FILE_W-1:0]   entry_index;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_q | out_ready_i;

  // One restoring division step: shift in the next dividend bit and try the subtraction.
  assign div_trial = {rem_q, quo_q[SIZE_W-1]};
  assign div_take  = (div_trial >= {1'b0, dvs_q});

  // Block count rounds the quotient up when a remainder is left.
  assign blk_count = {1'b0, quo_q} + (SIZE_W + 1)'(rem_q != '0);

  // Mask of the blocks in the current row that lie below the block count.
  always_comb begin
    if (32'(row_q) < 32'(blk_total_q >> ROW_BW)) begin
      row_mask = '1;
    end else begin
      row_mask = ~({ROW_W{1'b1}} << blk_total_q[ROW_BW-1:0]);
    end
  end

  // Lowest missing block left in the working row.
  always_comb begin
    first_bit = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (work_q[i]) begin
        first_bit = ROW_BW'(i);
      end
    end
  end

  assign entry_index = (FILE_W'(row_q) << ROW_BW) | FILE_W'(first_bit);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[row_q] <= mem_wdata;
    end
    rd_q <= mem[row_q];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cur_file_d  = cur_file_q;
    blk_total_d = blk_total_q;
    miss_cnt_d  = miss_cnt_q;
    new_file_d  = new_file_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    div_cnt_d   = div_cnt_q;
    row_d       = row_q;
    bit_d       = bit_q;
    last_row_d  = last_row_q;
    code_d      = code_q;
    listed_d    = listed_q;
    emit_d      = emit_q;
    work_d      = work_q;
    mem_we      = 1'b0;
    mem_wdata   = '1;

    out_valid_d = out_valid_q & ~out_ready_i;
    kind_d      = kind_q;
    ocode_d     = ocode_q;
    ofile_d     = ofile_q;
    value_d     = value_q;
    last_d      = last_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire && frame_ok_i) begin
          case (req_type_i)
            REQ_START: begin
              if (file_number_i != cur_file_q && block_length_i != '0) begin
                new_file_d = file_number_i;
                quo_d      = file_size_i;
                rem_d      = '0;
                dvs_d      = block_length_i;
                div_cnt_d  = '0;
                state_d    = S_DIV;
              end
            end
            REQ_DATA: begin
              if (file_number_i == cur_file_q && block_seq_i < SEQ_W'(blk_total_q)) begin
                row_d   = block_seq_i[RAW+ROW_BW-1:ROW_BW];
                bit_d   = block_seq_i[ROW_BW-1:0];
                state_d = S_DRD;
              end
            end
            REQ_STATUS: begin
              if (file_number_i == cur_file_q) begin
                if (miss_cnt_q == blk_total_q) begin
                  code_d = ST_NOTHING;
                end else if (miss_cnt_q == '0) begin
                  code_d = ST_COMPLETE;
                end else begin
                  code_d = ST_MISSING;
                end
                if (32'(miss_cnt_q) > 32'(MAX_REPORT)) begin
                  listed_d = LW'(MAX_REPORT);
                end else begin
                  listed_d = LW'(miss_cnt_q);
                end
                state_d = S_HDR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Bit-serial division of the file size by the block length.
      S_DIV: begin
        quo_d = {quo_q[SIZE_W-2:0], div_take};
        if (div_take) begin
          rem_d = BLEN_W'(div_trial - {1'b0, dvs_q});
        end else begin
          rem_d = div_trial[BLEN_W-1:0];
        end
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == DCW'(SIZE_W - 1)) begin
          state_d = S_DCHK;
        end
      end

      // Accept the new file only if its blocks fit in the bitmap.
      S_DCHK: begin
        if (blk_count > (SIZE_W + 1)'(MAX_BLOCKS)) begin
          state_d = S_IDLE;
        end else begin
          cur_file_d  = new_file_q;
          blk_total_d = BT_W'(blk_count);
          miss_cnt_d  = BT_W'(blk_count);
          last_row_d  = RAW'((blk_count - 1'b1) >> ROW_BW);
          row_d       = '0;
          if (blk_count == '0) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_FILL;
          end
        end
      end

      // Mark every block of the new file missing, one row a cycle.
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
        if (row_q == last_row_q) begin
          state_d = S_IDLE;
        end else begin
          row_d = row_q + 1'b1;
        end
      end

      S_DRD: begin
        state_d = S_DWR;
      end

      // Clear the block's mark and count it once if it was still missing.
      S_DWR: begin
        if (rd_q[bit_q]) begin
          mem_we             = 1'b1;
          mem_wdata          = rd_q;
          mem_wdata[bit_q]   = 1'b0;
          miss_cnt_d         = miss_cnt_q - 1'b1;
        end
        state_d = S_IDLE;
      end

      // Reply header.
      S_HDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_HEADER;
          ocode_d     = code_q;
          ofile_d     = cur_file_q;
          if (code_q == ST_MISSING) begin
            value_d = VALUE_W'(listed_q);
            last_d  = 1'b0;
            row_d   = '0;
            emit_d  = '0;
            state_d = S_SRD;
          end else begin
            value_d = '0;
            last_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      S_SRD: begin
        state_d = S_SLD;
      end

      S_SLD: begin
        work_d  = rd_q & row_mask;
        state_d = S_SCAN;
      end

      // List missing blocks of the row, lowest first, then move to the next row.
      S_SCAN: begin
        if (work_q == '0) begin
          row_d   = row_q + 1'b1;
          state_d = S_SRD;
        end else if (slot_free) begin
          out_valid_d       = 1'b1;
          kind_d            = KIND_ENTRY;
          ocode_d           = ST_MISSING;
          ofile_d           = cur_file_q;
          value_d           = entry_index[VALUE_W-1:0];
          last_d            = (emit_q + 1'b1 == listed_q);
          work_d[first_bit] = 1'b0;
          emit_d            = emit_q + 1'b1;
          if (emit_q + 1'b1 == listed_q) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_file_q  <= '0;
      blk_total_q <= '0;
      miss_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_file_q  <= cur_file_d;
      blk_total_q <= blk_total_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    new_file_q <= new_file_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    div_cnt_q  <= div_cnt_d;
    row_q      <= row_d;
    bit_q      <= bit_d;
    last_row_q <= last_row_d;
    code_q     <= code_d;
    listed_q   <= listed_d;
    emit_q     <= emit_d;
    work_q     <= work_d;
    kind_q     <= kind_d;
    ocode_q    <= ocode_d;
    ofile_q    <= ofile_d;
    value_q    <= value_d;
    last_q     <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign status_code_o = ocode_q;
  assign reply_file_o  = ofile_q;
  assign value_o       = value_q;
  assign last_o        = last_q;

endmodule
